// ----- hw/rtl/pcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcsc_pkg
// Shared constants and types for the per-channel scale calibration block.
// ----------------------------------------------------------------------------
package pcsc_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CHAN_CNT_W   = 7;
  localparam int ROW_W        = 16;
  localparam int SAMPLE_W     = 16;
  localparam int BITS_W       = 5;
  localparam int QMAX_W       = 16;
  localparam int SCALE_W      = 24;
  localparam int ZP_W         = 32;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  // divider operands: numerator 2*n+d, denominator 2*d
  localparam int DIV_NUM_W = 41;
  localparam int DIV_DEN_W = QMAX_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ROW_COUNT     = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] REG_QUANT_BITS    = 2'd2;
  localparam logic [1:0] REG_SYMMETRIC     = 2'd3;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- hw/rtl/pcsc_ram.sv -----
// ----------------------------------------------------------------------------
// pcsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/pcsc_div.sv -----
// ----------------------------------------------------------------------------
// pcsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcsc_pkg::div_req_t req_i,
  output pcsc_pkg::div_rsp_t rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [pcsc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [pcsc_pkg::DIV_DEN_W-1:0] den_q, den_d;
  logic [pcsc_pkg::DIV_DEN_W-1:0] rem_q, rem_d;
  logic [pcsc_pkg::DIV_NUM_W-1:0] quo_q, quo_d;
  logic [pcsc_pkg::DIV_DEN_W:0]   trial;
  logic                           fits;

  // shift the next numerator bit into the partial remainder
  assign trial = {rem_q, quo_q[pcsc_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = pcsc_pkg::DIV_CNT_W'(pcsc_pkg::DIV_NUM_W - 1);
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = req_i.num;
    end else if (busy_q) begin
      rem_d = fits ? pcsc_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
                   : trial[pcsc_pkg::DIV_DEN_W-1:0];
      quo_d = {quo_q[pcsc_pkg::DIV_NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ----- hw/rtl/per_channel_scale_calibration.sv -----
// A sample outside the final row occupies the block for accept and store update only; a
// final-row sample goes on through operand preparation, the scale division and, if asymmetric,
// the zero-point division to the output state (a zero range skips the divisions); each
// division is 41 steps of the shared bit-serial divider. Input stalls until the block is idle.
// Reset: registers return to row_count 1, channel_count 64, quant_bits 8, symmetric 1;
// positions clear at once, the min/max store is not cleared (row 0 always writes it first).
// ----------------------------------------------------------------------------
// per_channel_scale_calibration
// Running per-channel min/max with scale and zero point on the last row.
// ----------------------------------------------------------------------------
module per_channel_scale_calibration (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pcsc_pkg::SAMPLE_W-1:0] in_sample_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pcsc_pkg::CH_W-1:0]          out_channel_o,
  output logic [pcsc_pkg::SCALE_W-1:0]       out_scale_o,
  output logic signed [pcsc_pkg::ZP_W-1:0]   out_zero_point_o,
  output logic                               out_last_o,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pcsc_pkg::PADDR_W-1:0]       paddr,
  input  logic [pcsc_pkg::PDATA_W-1:0]       pwdata,
  output logic [pcsc_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPD    = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_SCL_GO = 3'd3;
  localparam logic [2:0] S_SCL_WT = 3'd4;
  localparam logic [2:0] S_ZP_GO  = 3'd5;
  localparam logic [2:0] S_ZP_WT  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  localparam int SW = pcsc_pkg::SAMPLE_W;
  localparam int NW = pcsc_pkg::DIV_NUM_W;
  localparam int DW = pcsc_pkg::DIV_DEN_W;
  localparam int CW = pcsc_pkg::CH_W;
  localparam int KW = pcsc_pkg::CHAN_CNT_W;
  localparam int RW = pcsc_pkg::ROW_W;

  // ---------------- configuration registers ----------------
  logic [RW-1:0]                  row_count_q;
  logic [KW-1:0]                  chan_count_q;
  logic [pcsc_pkg::BITS_W-1:0]    qbits_q;
  logic                           sym_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q  <= RW'(1);
      chan_count_q <= KW'(64);
      qbits_q      <= pcsc_pkg::BITS_W'(8);
      sym_q        <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        pcsc_pkg::REG_ROW_COUNT:     row_count_q  <= pwdata[RW-1:0];
        pcsc_pkg::REG_CHANNEL_COUNT: chan_count_q <= pwdata[KW-1:0];
        pcsc_pkg::REG_QUANT_BITS:    qbits_q      <= pwdata[pcsc_pkg::BITS_W-1:0];
        pcsc_pkg::REG_SYMMETRIC:     sym_q        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      pcsc_pkg::REG_ROW_COUNT:     prdata = pcsc_pkg::PDATA_W'(row_count_q);
      pcsc_pkg::REG_CHANNEL_COUNT: prdata = pcsc_pkg::PDATA_W'(chan_count_q);
      pcsc_pkg::REG_QUANT_BITS:    prdata = pcsc_pkg::PDATA_W'(qbits_q);
      pcsc_pkg::REG_SYMMETRIC:     prdata = pcsc_pkg::PDATA_W'(sym_q);
      default: ;
    endcase
  end

  // clamped settings
  logic [RW-1:0]               rows;
  logic [KW-1:0]               chans;
  logic [pcsc_pkg::BITS_W-1:0] bits;

  assign rows  = (row_count_q == '0) ? RW'(1) : row_count_q;
  assign chans = (chan_count_q == '0) ? KW'(1)
               : (chan_count_q > KW'(pcsc_pkg::MAX_CHANNELS)) ? KW'(pcsc_pkg::MAX_CHANNELS)
               : chan_count_q;
  assign bits  = (qbits_q < pcsc_pkg::BITS_W'(2))  ? pcsc_pkg::BITS_W'(2)
               : (qbits_q > pcsc_pkg::BITS_W'(16)) ? pcsc_pkg::BITS_W'(16)
               : qbits_q;

  // ---------------- sequencer ----------------
  logic [2:0] state_q, state_d;
  logic       in_acc;
  logic       out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // position tracking
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] r_cur;
  logic [CW-1:0] c_cur;
  logic [RW:0]   r_inc;
  logic [KW-1:0] c_inc;

  assign c_cur = (KW'(col_q) >= chans) ? '0 : col_q;
  assign r_cur = (row_q >= rows) ? '0 : row_q;
  assign r_inc = {1'b0, r_cur} + 1'b1;
  assign c_inc = KW'(c_cur) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (c_inc >= chans) begin
        col_q <= '0;
        row_q <= (r_inc >= {1'b0, rows}) ? '0 : r_inc[RW-1:0];
      end else begin
        col_q <= c_inc[CW-1:0];
      end
    end
  end

  // per-transaction context
  logic signed [SW-1:0] sample_q;
  logic [CW-1:0]        addr_q;
  logic                 first_q, final_q, last_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_sample_i;
      addr_q   <= c_cur;
      first_q  <= (r_cur == '0);
      final_q  <= (r_cur == rows - 1'b1);
      last_q   <= (KW'(c_cur) == chans - 1'b1);
    end
  end

  // ---------------- min/max store ----------------
  logic [2*SW-1:0]      ram_rdata;
  logic signed [SW-1:0] old_lo, old_hi, new_lo, new_hi;
  logic signed [SW-1:0] lo_q, hi_q;

  assign old_lo = ram_rdata[2*SW-1:SW];
  assign old_hi = ram_rdata[SW-1:0];
  assign new_lo = (first_q || sample_q < old_lo) ? sample_q : old_lo;
  assign new_hi = (first_q || sample_q > old_hi) ? sample_q : old_hi;

  pcsc_ram #(
    .WIDTH(2 * SW),
    .DEPTH(pcsc_pkg::MAX_CHANNELS)
  ) u_minmax (
    .clk_i  (clk_i),
    .we_i   (state_q == S_UPD),
    .waddr_i(addr_q),
    .wdata_i({new_lo, new_hi}),
    .raddr_i(c_cur),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      lo_q <= new_lo;
      hi_q <= new_hi;
    end
  end

  // ---------------- operand preparation ----------------
  logic [SW:0]                  lo_ext, hi_ext, alo17, ahi17, rng17;
  logic [SW-1:0]                alo, ahi, amax, rng, base;
  logic [SW:0]                  qmax_a17, qmax_s17;
  logic [pcsc_pkg::QMAX_W-1:0]  qmax;
  logic [2*SW-1:0]              prod;

  assign lo_ext   = {lo_q[SW-1], lo_q};
  assign hi_ext   = {hi_q[SW-1], hi_q};
  assign alo17    = lo_q[SW-1] ? ((SW+1)'(0) - lo_ext) : lo_ext;
  assign ahi17    = hi_q[SW-1] ? ((SW+1)'(0) - hi_ext) : hi_ext;
  assign alo      = alo17[SW-1:0];
  assign ahi      = ahi17[SW-1:0];
  assign amax     = (alo > ahi) ? alo : ahi;
  assign rng17    = hi_ext - lo_ext;
  assign rng      = rng17[SW-1:0];
  assign qmax_a17 = ((SW+1)'(1) << bits) - 1'b1;
  assign qmax_s17 = ((SW+1)'(1) << (bits - 1'b1)) - 1'b1;
  assign qmax     = sym_q ? qmax_s17[pcsc_pkg::QMAX_W-1:0] : qmax_a17[pcsc_pkg::QMAX_W-1:0];
  assign base     = sym_q ? amax : rng;
  assign prod     = {{SW{1'b0}}, alo} * {{(2*SW-pcsc_pkg::QMAX_W){1'b0}}, qmax};

  logic [NW-1:0] scl_num_q, zp_num_q;
  logic [DW-1:0] scl_den_q, zp_den_q;

  // div_round(n, d) = floor((2n + d) / 2d); the Q16.8 and Q23.8 shifts fold into n
  always_ff @(posedge clk_i) begin
    if (state_q == S_PREP) begin
      scl_num_q <= (NW'(base) << 9) + NW'(qmax);
      scl_den_q <= {qmax, 1'b0};
      zp_num_q  <= (NW'(prod) << 9) + NW'(rng);
      zp_den_q  <= {rng, 1'b0};
    end
  end

  // ---------------- shared divider ----------------
  pcsc_pkg::div_req_t div_req;
  pcsc_pkg::div_rsp_t div_rsp;

  assign div_req.start = (state_q == S_SCL_GO) || (state_q == S_ZP_GO);
  assign div_req.num   = (state_q == S_ZP_GO) ? zp_num_q : scl_num_q;
  assign div_req.den   = (state_q == S_ZP_GO) ? zp_den_q : scl_den_q;

  pcsc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // ---------------- result assembly ----------------
  logic [pcsc_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic [pcsc_pkg::ZP_W-1:0]    zp_q, zp_d;
  logic [pcsc_pkg::ZP_W-1:0]    zp_mag;

  always_comb begin
    zp_mag = '0;
    if (lo_q[SW-1]) begin
      zp_mag = (div_rsp.quot > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
             : div_rsp.quot[pcsc_pkg::ZP_W-1:0];
    end else begin
      zp_mag = (div_rsp.quot > NW'(32'h8000_0000)) ? 32'h8000_0000
             : div_rsp.quot[pcsc_pkg::ZP_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    scale_d = scale_q;
    zp_d    = zp_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_UPD;
      end
      S_UPD: begin
        state_d = final_q ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        zp_d = '0;
        if (base == '0) begin
          scale_d = pcsc_pkg::SCALE_W'(65536);
          state_d = S_OUT;
        end else begin
          state_d = S_SCL_GO;
        end
      end
      S_SCL_GO: state_d = S_SCL_WT;
      S_SCL_WT: begin
        if (div_rsp.done) begin
          scale_d = (div_rsp.quot > NW'(24'hFF_FFFF)) ? 24'hFF_FFFF
                  : div_rsp.quot[pcsc_pkg::SCALE_W-1:0];
          state_d = sym_q ? S_OUT : S_ZP_GO;
        end
      end
      S_ZP_GO: state_d = S_ZP_WT;
      S_ZP_WT: begin
        if (div_rsp.done) begin
          if (lo_q[SW-1]) begin
            zp_d = zp_mag;
          end else if (lo_q != '0) begin
            zp_d = pcsc_pkg::ZP_W'(0) - zp_mag;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
    zp_q    <= zp_d;
  end

  // ---------------- output register ----------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_channel_o    <= addr_q;
      out_scale_o      <= scale_q;
      out_zero_point_o <= zp_q;
      out_last_o       <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------- assertions ----------------
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_SCL_WT || state_q == S_ZP_WT))
    else $error("divider finished outside a wait state");

  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_UPD))
    else $error("accepted sample did not reach store update");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_o || !out_stall_i))
    else $error("pending result overwritten");

  a_sym_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sym_q) |-> (out_zero_point_o == '0))
    else $error("nonzero zero point in symmetric mode");

endmodule
